### design/lgs_pkg.sv
// shared types and constants of the linear gradient shader
package lgs_pkg;

  // color word, alpha in the top byte
  typedef logic [31:0] argb_t;

  // boundary modes, code 3 behaves as extended
  localparam logic [1:0] MODE_EXTENDED  = 2'd0;
  localparam logic [1:0] MODE_TRUNCATED = 2'd1;
  localparam logic [1:0] MODE_PERIODIC  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] REG_STEP_X      = 3'd2;
  localparam logic [2:0] REG_STEP_Y      = 3'd3;
  localparam logic [2:0] REG_MODE        = 3'd4;
  localparam logic [2:0] REG_STOP_POS    = 3'd5;
  localparam logic [2:0] REG_COLORS_LOW  = 3'd6;
  localparam logic [2:0] REG_COLORS_HIGH = 3'd7;

  // divider depths: wrap remainder and blend fraction
  localparam int WRAP_BITS = 16;
  localparam int FRAC_BITS = 9;

endpackage

### design/lgs_pixel_if.sv
// pixel coordinate channel and result color channel
interface lgs_pixel_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic               run_last;
  modport source (output valid, pixel_x, pixel_y, run_last, input ready);
  modport sink (input valid, pixel_x, pixel_y, run_last, output ready);
endinterface

interface lgs_color_if;
  logic                valid;
  logic                ready;
  lgs_pkg::argb_t      color_argb;
  logic                run_end;
  modport source (output valid, color_argb, run_end, input ready);
  modport sink (input valid, color_argb, run_end, output ready);
endinterface

### design/linear_gradient_shader.sv
// linear gradient shader: pixel coordinate in, ARGB color out
//
// in_pixel carries one coordinate word (pixel_x, pixel_y, run_last); out_color
// returns one color word (color_argb, run_end) per coordinate, in order.
// Configuration is to be written through cfg_we/cfg_index/cfg_data only while
// the block is idle (the block does not enforce this); register i of the list is index i.
// The datapath is a 32 stage pipeline that ends in the out_color register; one
// word is accepted every cycle unless the receiver stalls with a word waiting.
// The length is set by the two restoring dividers, 16 stages for the periodic
// remainder and 9 stages for the blend fraction, one quotient bit per stage,
// plus the offset, the projection multiply, the saturation, the boundary
// check, the wrap result, the stop search and the blend.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// in_pixel.ready drops in the same cycle; nothing is lost or repeated.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the
// register defaults: origin 0, step_x 1.0, step_y 0, extended mode, all stops
// at position 0 with color 0.
module linear_gradient_shader #(
  parameter int STOP_COUNT = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  lgs_pixel_if.sink     in_pixel,
  lgs_color_if.source   out_color,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data
);

  localparam int LAST = STOP_COUNT - 1;
  localparam int WB = lgs_pkg::WRAP_BITS;
  localparam int FB = lgs_pkg::FRAC_BITS;

  typedef struct packed {
    logic               last;
    logic               done;
    lgs_pkg::argb_t     col;
    logic signed [15:0] t;
    logic               wrap;
    logic               neg;
    logic [15:0]        mag;
    logic [15:0]        per;
    logic signed [15:0] front;
    logic [15:0]        rem;
  } wrap_ctx_t;

  typedef struct packed {
    logic           last;
    logic           done;
    lgs_pkg::argb_t col;
    lgs_pkg::argb_t col_r;
    logic [15:0]    rem;
    logic [15:0]    den;
    logic [8:0]     q;
  } frac_ctx_t;

  // configuration registers
  logic signed [15:0] origin_x_r, origin_y_r, step_x_r, step_y_r;
  logic [1:0]         mode_r;
  logic [63:0]        stop_pos_r, colors_low_r, colors_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      step_x_r      <= 16'sd4096;
      step_y_r      <= '0;
      mode_r        <= lgs_pkg::MODE_EXTENDED;
      stop_pos_r    <= '0;
      colors_low_r  <= '0;
      colors_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lgs_pkg::REG_ORIGIN_X:    origin_x_r    <= cfg_data[15:0];
        lgs_pkg::REG_ORIGIN_Y:    origin_y_r    <= cfg_data[15:0];
        lgs_pkg::REG_STEP_X:      step_x_r      <= cfg_data[15:0];
        lgs_pkg::REG_STEP_Y:      step_y_r      <= cfg_data[15:0];
        lgs_pkg::REG_MODE:        mode_r        <= cfg_data[1:0];
        lgs_pkg::REG_STOP_POS:    stop_pos_r    <= cfg_data;
        lgs_pkg::REG_COLORS_LOW:  colors_low_r  <= cfg_data;
        lgs_pkg::REG_COLORS_HIGH: colors_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stop table views
  logic signed [15:0] spos [4];
  lgs_pkg::argb_t     scol [4];

  always_comb begin
    spos[0] = stop_pos_r[15:0];
    spos[1] = stop_pos_r[31:16];
    spos[2] = stop_pos_r[47:32];
    spos[3] = stop_pos_r[63:48];
    scol[0] = colors_low_r[31:0];
    scol[1] = colors_low_r[63:32];
    scol[2] = colors_high_r[31:0];
    scol[3] = colors_high_r[63:32];
  end

  // pipeline advance: everything moves unless a finished word is stuck
  logic out_valid_r;
  logic adv;
  assign adv = !out_valid_r || out_color.ready;
  assign in_pixel.ready = adv;

  // stage registers
  logic               v1_r, v2_r, v3_r, v4_r, vw_r, vs_r;
  logic               vd_r [WB];
  logic               vf_r [FB];
  logic               l1_r, l2_r, l3_r;
  logic signed [16:0] dx1_r, dy1_r;
  logic signed [32:0] px2_r, py2_r;
  logic signed [15:0] t3_r;
  wrap_ctx_t          w4_r, w4_nxt;
  wrap_ctx_t          wd_r [WB];
  wrap_ctx_t          wd_nxt [WB];
  frac_ctx_t          fw_r;
  frac_ctx_t          fs_r, fs_nxt;
  frac_ctx_t          fd_r [FB];
  frac_ctx_t          fd_nxt [FB];
  logic signed [15:0] tw_r;
  logic               lw_r, dw_r;
  lgs_pkg::argb_t     cw_r;
  lgs_pkg::argb_t     out_argb_r, out_argb_nxt;
  logic               out_last_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      vw_r <= 1'b0; vs_r <= 1'b0; out_valid_r <= 1'b0;
      for (int k = 0; k < WB; k++) vd_r[k] <= 1'b0;
      for (int j = 0; j < FB; j++) vf_r[j] <= 1'b0;
    end else if (adv) begin
      v1_r <= in_pixel.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      vd_r[0] <= v4_r;
      for (int k = 1; k < WB; k++) vd_r[k] <= vd_r[k-1];
      vw_r <= vd_r[WB-1];
      vs_r <= vw_r;
      vf_r[0] <= vs_r;
      for (int j = 1; j < FB; j++) vf_r[j] <= vf_r[j-1];
      out_valid_r <= vf_r[FB-1];
    end
  end

  // saturated Q12.4 axis position
  logic signed [33:0] acc;
  logic signed [25:0] accq;
  logic signed [15:0] t_sat;

  always_comb begin
    acc  = 34'(px2_r) + 34'(py2_r);
    accq = 26'(acc >>> 8);
    if (accq > 26'sd32767)       t_sat = 16'sh7fff;
    else if (accq < -26'sd32768) t_sat = 16'sh8000;
    else                         t_sat = accq[15:0];
  end

  // boundary handling: truncated fade and periodic wrap setup
  logic signed [16:0] front17, back17, period17, diff_lo, diff_hi, d17;
  logic [4:0]         fade_k;
  logic [12:0]        fade_a;
  logic               fade_en;

  always_comb begin
    front17  = 17'(spos[0]);
    back17   = 17'(spos[2'(LAST)]);
    period17 = back17 - front17;
    diff_lo  = front17 - 17'(t3_r);
    diff_hi  = 17'(t3_r) - back17;
    d17      = 17'(t3_r) - front17;
    fade_k   = 5'd0;
    fade_en  = 1'b0;
    w4_nxt       = '0;
    w4_nxt.last  = l3_r;
    w4_nxt.t     = t3_r;
    w4_nxt.front = spos[0];
    w4_nxt.per   = period17[15:0];
    w4_nxt.neg   = d17 < 0;
    w4_nxt.mag   = (d17 < 0) ? ~d17[15:0] : d17[15:0];
    w4_nxt.wrap  = (mode_r == lgs_pkg::MODE_PERIODIC) && (period17 > 0)
                   && (17'(t3_r) < front17 || 17'(t3_r) > back17);
    if (mode_r == lgs_pkg::MODE_TRUNCATED) begin
      if (17'(t3_r) < front17) begin
        w4_nxt.done = 1'b1;
        fade_k      = 5'd16 - diff_lo[4:0];
        fade_en     = diff_lo < 17'sd16;
        w4_nxt.col  = (diff_lo >= 17'sd16) ? '0 : scol[0];
      end else if (17'(t3_r) > back17) begin
        w4_nxt.done = 1'b1;
        fade_k      = 5'd16 - diff_hi[4:0];
        fade_en     = diff_hi < 17'sd16;
        w4_nxt.col  = (diff_hi >= 17'sd16) ? '0 : scol[2'(LAST)];
      end
    end
    fade_a = 13'd255 * 13'(fade_k);
    if (fade_en) w4_nxt.col[31:24] = fade_a[11:4];
  end

  // one remainder bit per stage of the wrap divider
  logic [16:0] wsh [WB];

  always_comb begin
    for (int k = 0; k < WB; k++) begin
      wd_nxt[k] = (k == 0) ? w4_r : wd_r[(k == 0) ? 0 : k - 1];
      if (k == 0) wd_nxt[k].rem = '0;
      wsh[k] = {wd_nxt[k].rem, wd_nxt[k].mag[4'(WB - 1 - k)]};
      if (wsh[k] >= {1'b0, wd_nxt[k].per}) wsh[k] = wsh[k] - {1'b0, wd_nxt[k].per};
      wd_nxt[k].rem = wsh[k][15:0];
    end
  end

  // wrapped position
  wrap_ctx_t   wl;
  logic [15:0] wm;

  always_comb begin
    wl = wd_r[WB-1];
    wm = wl.neg ? (wl.per - 16'd1 - wl.rem) : wl.rem;
  end

  // stop search
  logic       found;
  logic [1:0] ridx;

  always_comb begin
    found = 1'b0;
    ridx  = 2'd0;
    for (int i = 0; i < STOP_COUNT; i++) begin
      if (!found && spos[i] >= tw_r) begin
        found = 1'b1;
        ridx  = 2'(i);
      end
    end
    fs_nxt      = '0;
    fs_nxt.last = lw_r;
    fs_nxt.done = dw_r;
    fs_nxt.col  = cw_r;
    if (!dw_r) begin
      if (!found) begin
        fs_nxt.done = 1'b1;
        fs_nxt.col  = scol[2'(LAST)];
      end else if (ridx == 2'd0) begin
        fs_nxt.done = 1'b1;
        fs_nxt.col  = scol[0];
      end else begin
        fs_nxt.col   = scol[ridx - 2'd1];
        fs_nxt.col_r = scol[ridx];
        fs_nxt.rem   = 16'(tw_r - spos[ridx - 2'd1]);
        fs_nxt.den   = 16'(spos[ridx] - spos[ridx - 2'd1]);
      end
    end
  end

  // one fraction bit per stage of the blend divider
  logic [16:0] fsh [FB];
  logic        fbit [FB];

  always_comb begin
    for (int j = 0; j < FB; j++) begin
      fd_nxt[j] = (j == 0) ? fs_r : fd_r[(j == 0) ? 0 : j - 1];
      fsh[j]  = (j == 0) ? {1'b0, fd_nxt[j].rem} : {fd_nxt[j].rem, 1'b0};
      fbit[j] = fsh[j] >= {1'b0, fd_nxt[j].den};
      if (fbit[j]) fsh[j] = fsh[j] - {1'b0, fd_nxt[j].den};
      fd_nxt[j].rem = fsh[j][15:0];
      fd_nxt[j].q   = {fd_nxt[j].q[7:0], fbit[j]};
    end
  end

  // per channel blend
  frac_ctx_t   fl;
  logic [8:0]  finv;
  logic [17:0] chs [4];

  always_comb begin
    fl   = fd_r[FB-1];
    finv = 9'd256 - fl.q;
    for (int c = 0; c < 4; c++) begin
      chs[c] = 18'(fl.col[8*c +: 8]) * 18'(finv) + 18'(fl.col_r[8*c +: 8]) * 18'(fl.q);
      out_argb_nxt[8*c +: 8] = chs[c][15:8];
    end
    if (fl.done) out_argb_nxt = fl.col;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      l1_r  <= in_pixel.run_last;
      dx1_r <= 17'(in_pixel.pixel_x) - 17'(origin_x_r);
      dy1_r <= 17'(in_pixel.pixel_y) - 17'(origin_y_r);
      l2_r  <= l1_r;
      px2_r <= dx1_r * step_x_r;
      py2_r <= dy1_r * step_y_r;
      l3_r  <= l2_r;
      t3_r  <= t_sat;
      w4_r  <= w4_nxt;
      for (int k = 0; k < WB; k++) wd_r[k] <= wd_nxt[k];
      lw_r  <= wl.last;
      dw_r  <= wl.done;
      cw_r  <= wl.col;
      tw_r  <= wl.wrap ? 16'(wl.front + signed'(wm)) : wl.t;
      fs_r  <= fs_nxt;
      for (int j = 0; j < FB; j++) fd_r[j] <= fd_nxt[j];
      out_argb_r <= out_argb_nxt;
      out_last_r <= fl.last;
    end
  end

  assign fw_r = fs_r;
  assign out_color.valid      = out_valid_r;
  assign out_color.color_argb = out_argb_r;
  assign out_color.run_end    = out_last_r;

  // checks
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_pixel.valid && in_pixel.ready |=> v1_r)
    else $error("accepted word did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v1_r) && $stable(vs_r) && $stable(vd_r[0]))
    else $error("pipeline moved during a stall");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    vf_r[FB-1] && !fd_r[FB-1].done |-> fd_r[FB-1].q <= 9'd256)
    else $error("blend fraction out of range");

  a_wrap_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vd_r[WB-1] && wd_r[WB-1].wrap |-> wd_r[WB-1].rem < wd_r[WB-1].per)
    else $error("wrap remainder not below period");

  a_search_used: assert property (@(posedge clk) disable iff (!rst_n)
    vs_r && !fw_r.done |-> fw_r.rem <= fw_r.den)
    else $error("blend offset beyond stop span");

endmodule
